### sv/itda_pkg.sv
// itda_pkg: shared constants and types for the integer to decimal ascii block
// holds widths, character codes, sequencer states and the datapath control word
// no dependencies
`default_nettype none

package itda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } itda_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic dshift;
    } itda_ctl_t;

endpackage

`default_nettype wire

### sv/itda_dabble.sv
// itda_dabble: bit-serial shift-add-3 binary to bcd converter
// magnitude shifts out msb first into the bcd register, then digits shift out by four
// depends on itda_pkg
`default_nettype none

module itda_dabble (
    input  wire logic                              clk,
    input  wire itda_pkg::itda_ctl_t               ctl,
    input  wire logic [itda_pkg::VALUE_WIDTH-1:0]  mag,
    output logic [3:0]                             top_digit
);
    import itda_pkg::*;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_WIDTH-1:0]   bcd_reg, bcd_next;
    logic [BCD_WIDTH-1:0]   adj;

    always_comb
    begin
        adj = bcd_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= DABBLE_LIMIT)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + DABBLE_ADD;
            end
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        if (ctl.load)
        begin
            mag_next = mag;
            bcd_next = '0;
        end
        else if (ctl.step)
        begin
            bcd_next = {adj[BCD_WIDTH-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
        end
        else if (ctl.dshift)
        begin
            bcd_next = {bcd_reg[BCD_WIDTH-5:0], 4'b0000};
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];

endmodule

`default_nettype wire

### sv/itda_ctrl.sv
// itda_ctrl: sequencer for conversion and character output
// steps the converter, skips leading zeros, emits sign and digits with registered outputs
// depends on itda_pkg
`default_nettype none

module itda_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 negative,
    input  wire logic [3:0]           top_digit,
    output logic                      busy,
    output itda_pkg::itda_ctl_t       ctl,
    output logic                      strobe,
    output logic [7:0]                char_code,
    output logic                      last,
    output logic [3:0]                byte_count
);
    import itda_pkg::*;

    itda_state_t          state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [DIG_CNT_W-1:0] left_reg, left_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 started_reg, started_next;
    logic                 strobe_reg, strobe_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic [3:0]           bytes_reg, bytes_next;
    logic                 done;
    logic                 emit;

    assign done = (left_reg == DIG_CNT_W'(1));
    assign emit = started_reg || (top_digit != 4'd0) || done;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_reg == BIT_CNT_W'(VALUE_WIDTH - 1))
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and counters
    always_comb
    begin
        ctl          = '0;
        bit_next     = bit_reg;
        left_next    = left_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;
        bytes_next   = 4'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load     = 1'b1;
                    bit_next     = '0;
                    left_next    = DIG_CNT_W'(NUM_DIGITS);
                    cnt_next     = 4'd0;
                    neg_next     = negative;
                    started_next = 1'b0;
                end
            end
            ST_CONV:
            begin
                ctl.step = 1'b1;
                bit_next = bit_reg + BIT_CNT_W'(1);
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                cnt_next    = cnt_reg + 4'd1;
            end
            ST_DIGITS:
            begin
                ctl.dshift = 1'b1;
                left_next  = left_reg - DIG_CNT_W'(1);
                if (emit)
                begin
                    started_next = 1'b1;
                    strobe_next  = 1'b1;
                    char_next    = CHAR_ZERO + {4'b0000, top_digit};
                    cnt_next     = cnt_reg + 4'd1;
                    last_next    = done;
                    bytes_next   = done ? cnt_reg + 4'd1 : 4'd0;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            strobe_reg  <= 1'b0;
            bit_reg     <= '0;
            left_reg    <= '0;
            cnt_reg     <= 4'd0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            strobe_reg  <= strobe_next;
            bit_reg     <= bit_next;
            left_reg    <= left_next;
            cnt_reg     <= cnt_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        bytes_reg <= bytes_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign char_code  = char_reg;
    assign last       = last_reg;
    assign byte_count = bytes_reg;

endmodule

`default_nettype wire

### sv/int_to_decimal_ascii.sv
// int_to_decimal_ascii: signed integer to decimal ascii text, one character per word
// top level; depends on itda_pkg, itda_dabble and itda_ctrl
//
// A number is taken when start is high and busy is low. The block then shifts the
// VALUE_WIDTH-bit magnitude through the shift-add-3 converter, one bit per cycle,
// and then scans the NUM_DIGITS bcd digits (10) one per cycle, dropping leading
// zeros; a negative number first passes through a state for the minus sign.
// busy stays high until the last bcd digit has been scanned, so a new number can only
// be taken once the block is back in idle. Characters come out
// most significant first, each on the ports for exactly one cycle with strobe
// high; the receiver cannot stall them. The final character of a number has last
// high and byte_count holding the character count; byte_count is zero otherwise.
// The most negative input converts correctly through its unsigned magnitude.
`default_nettype none

module int_to_decimal_ascii (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [itda_pkg::VALUE_WIDTH-1:0] value,
    output logic                                   strobe,
    output logic [7:0]                             char_code,
    output logic                                   last,
    output logic [3:0]                             byte_count
);
    import itda_pkg::*;

    itda_ctl_t              ctl;
    logic [3:0]             top_digit;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] mag;

    assign negative = value[VALUE_WIDTH-1];
    assign mag      = negative ? (~value + VALUE_WIDTH'(1)) : value;

    itda_dabble u_dabble (
        .clk       (clk),
        .ctl       (ctl),
        .mag       (mag),
        .top_digit (top_digit)
    );

    itda_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .negative   (negative),
        .top_digit  (top_digit),
        .busy       (busy),
        .ctl        (ctl),
        .strobe     (strobe),
        .char_code  (char_code),
        .last       (last),
        .byte_count (byte_count)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting a number");

    a_mid_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("non-final character while idle");

    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((last && byte_count != 4'd0) || (!last && byte_count == 4'd0)))
        else $error("byte count does not match last flag");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character right after final character");

    a_step_only_converting: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (busy && !strobe))
        else $error("converter stepping outside conversion");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for int_to_decimal_ascii
// drives numbers, predicts the decimal text of each one and checks every character word
// depends on itda_pkg and the int_to_decimal_ascii rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itda_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;
    localparam int DIGIT_MAX   = 24;

    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
        logic [3:0] count;
    } char_word_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          strobe;
    logic [7:0]                    char_code;
    logic                          last;
    logic [3:0]                    byte_count;

    char_word_t pending_chars[$];
    int         fail_cnt;
    int         cycle_cnt;

    int_to_decimal_ascii u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .char_code  (char_code),
        .last       (last),
        .byte_count (byte_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // expected text of one number, most significant character first
    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digs [DIGIT_MAX];
        logic                   neg;
        int                     nd;
        int                     total;
        char_word_t             w;
        neg = v[VALUE_WIDTH-1];
        mag = neg ? (~v + 1'b1) : v;
        nd  = 0;
        do
        begin
            digs[nd] = 4'(mag % 10);
            nd       = nd + 1;
            mag      = mag / 10;
        end
        while (mag != 0 && nd < DIGIT_MAX);
        total = nd + (neg ? 1 : 0);
        if (neg)
        begin
            w.code    = CHAR_MINUS;
            w.is_last = 1'b0;
            w.count   = 4'd0;
            pending_chars.push_back(w);
        end
        for (int d = nd - 1; d >= 0; d--)
        begin
            w.code    = CHAR_ZERO + 8'(digs[d]);
            w.is_last = (d == 0);
            w.count   = (d == 0) ? 4'(total) : 4'd0;
            pending_chars.push_back(w);
        end
    endfunction

    always @(posedge clk)
    begin
        char_word_t exp_w;
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                fail_cnt = fail_cnt + 1;
                if (fail_cnt <= MAX_SHOWN)
                    $display("unexpected word: char %0d last %0b count %0d",
                             char_code, last, byte_count);
            end
            else
            begin
                exp_w = pending_chars.pop_front();
                if (char_code !== exp_w.code || last !== exp_w.is_last
                    || byte_count !== exp_w.count)
                begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("mismatch: expected %0d %0b %0d, got %0d %0b %0d",
                                 exp_w.code, exp_w.is_last, exp_w.count,
                                 char_code, last, byte_count);
                end
            end
        end
    end

    // start stays high from one word to the next inside a burst
    task automatic send_word(input logic [VALUE_WIDTH-1:0] v);
        @(negedge clk);
        start = 1'b1;
        value = v;
        do
            @(posedge clk);
        while (busy);
        predict_text(v);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            value = $urandom;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic wait_all_chars();
        idle_gap(1);
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        longint                 lo;
        longint                 hi;
        int                     nd;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom;
            2:
            begin
                nd = $urandom_range(1, 10);
                lo = 1;
                repeat (nd - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'sd2147483647)
                    hi = 64'sd2147483647;
                if (nd == 1)
                    lo = 0;
                v = $urandom_range(32'(hi), 32'(lo));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            3:
            begin
                v = $urandom_range(0, 20);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                else
                    v = 32'h8000_0000 + $urandom_range(0, 3);
            end
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_word(32'd0);
        send_word(32'd1);
        send_word(-32'sd1);
        send_word(32'd9);
        send_word(32'd10);
        send_word(-32'sd10);
        send_word(32'd99);
        send_word(32'd100);
        send_word(32'd999999999);
        send_word(32'd1000000000);
        send_word(-32'sd1000000000);
        send_word(32'd123456789);
        send_word(-32'sd123456789);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h8000_0001);
        send_word(32'h5555_5555);
        send_word(32'hAAAA_AAAA);
        wait_all_chars();
    endtask

    task automatic test_back_to_back();
        repeat (20) send_word(pick_value());
        wait_all_chars();
    endtask

    task automatic test_random_bursts();
        int burst;
        int sent;
        sent = 0;
        while (sent < 140)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                send_word(pick_value());
                sent = sent + 1;
            end
            if ($urandom_range(0, 9) == 0)
                wait_all_chars();
            else if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 60));
        end
        wait_all_chars();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        value     = '0;
        fail_cnt  = 0;
        cycle_cnt = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_random_bursts();

        repeat (60) @(posedge clk);
        fail_cnt = fail_cnt + pending_chars.size();
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
